// ===== src/aesu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesu_pkg
// Shared constants and types of the ADC event stream unpacker.
// ----------------------------------------------------------------------------
package aesu_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEPT_W      = (CNT_W > 6) ? CNT_W : 6;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENTRY_W     = 19;

    localparam logic [15:0] SENTINEL_HALF = 16'hFFFF;

    localparam logic [1:0] KIND_ENTRY  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  channel_number;
        logic [11:0] sample_value;
        logic        under_flag;
        logic        over_flag;
        logic [4:0]  geo_address;
        logic [6:0]  crate_number;
        logic [5:0]  entry_total;
        logic        truncated;
        logic        is_last;
    } res_beat_t;

endpackage

// ===== src/aesu_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesu_entry_ram
// Entry buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aesu_entry_ram (
    input  logic                            aclk,
    input  aesu_pkg::ram_req_t              req,
    output logic [aesu_pkg::ENTRY_W-1:0]    rd_data
);
    import aesu_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== src/aesu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesu_ctrl
// Word pairing, header and data parsing, and the emission sequencer that
// reads the entry buffer back at the end of an event.
// ----------------------------------------------------------------------------
module aesu_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_word,
    output aesu_pkg::ram_req_t              ram_req,
    input  logic [aesu_pkg::ENTRY_W-1:0]    ram_rd_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output aesu_pkg::res_beat_t             res_beat
);
    import aesu_pkg::*;

    typedef enum logic [4:0] {
        S_RUN  = 5'b00001,
        S_READ = 5'b00010,
        S_PUSH = 5'b00100,
        S_MARK = 5'b01000,
        S_REJ  = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_DATA  = 4'b0010,
        M_EOB   = 4'b0100,
        M_TRAIL = 4'b1000
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic               half_reg, half_next;
    logic [15:0]        low_reg, low_next;
    logic [7:0]         count_reg, count_next;
    logic [8:0]         pairs_reg, pairs_next;
    logic [KEPT_W-1:0]  kept_reg, kept_next;
    logic [KEPT_W-1:0]  idx_reg, idx_next;
    logic [4:0]         geo_reg, geo_next;
    logic [6:0]         crate_reg, crate_next;
    logic               drop_reg, drop_next;
    logic [4:0]         rej_geo_reg, rej_geo_next;
    logic [6:0]         rej_crate_reg, rej_crate_next;
    logic               rej_drop_reg, rej_drop_next;

    logic               pair_done;
    logic               sentinel;
    logic [8:0]         pairs_inc;
    logic [KEPT_W-1:0]  idx_inc;

    assign s_ready   = (state_reg == S_RUN);
    assign pair_done = s_valid && s_ready && half_reg;
    assign sentinel  = (low_reg == SENTINEL_HALF) && (s_word == SENTINEL_HALF);
    assign pairs_inc = pairs_reg + 9'd1;
    assign idx_inc   = idx_reg + KEPT_W'(1);

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        half_next      = half_reg;
        low_next       = low_reg;
        count_next     = count_reg;
        pairs_next     = pairs_reg;
        kept_next      = kept_reg;
        idx_next       = idx_reg;
        geo_next       = geo_reg;
        crate_next     = crate_reg;
        drop_next      = drop_reg;
        rej_geo_next   = rej_geo_reg;
        rej_crate_next = rej_crate_reg;
        rej_drop_next  = rej_drop_reg;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = kept_reg[ADDR_W-1:0];
        ram_req.wr_data = {s_word[4:0], low_reg[13], low_reg[12], low_reg[11:0]};
        ram_req.rd_en   = (state_reg == S_READ);
        ram_req.rd_addr = idx_reg[ADDR_W-1:0];

        if (s_valid && s_ready && !half_reg) begin
            low_next  = s_word;
            half_next = 1'b1;
        end

        if (pair_done) begin
            half_next = 1'b0;
            unique case (mode_reg)
                M_IDLE: begin
                    if (!sentinel) begin
                        count_next = low_reg[15:8];
                        geo_next   = s_word[15:11];
                        crate_next = s_word[9:3];
                        pairs_next = 9'd0;
                        kept_next  = '0;
                        drop_next  = 1'b0;
                        mode_next  = M_DATA;
                    end
                end
                M_DATA: begin
                    if (s_word[10]) begin
                        mode_next = M_TRAIL;
                    end else begin
                        pairs_next = pairs_inc;
                        if (!s_word[9]) begin
                            if (kept_reg < KEPT_W'(MAX_ENTRIES)) begin
                                ram_req.wr_en = 1'b1;
                                kept_next     = kept_reg + KEPT_W'(1);
                            end else begin
                                drop_next = 1'b1;
                            end
                        end
                        if ({1'b0, pairs_inc} >= ({2'b00, count_reg} + 10'd2)) begin
                            mode_next = M_EOB;
                        end
                    end
                end
                M_EOB: begin
                    mode_next = M_TRAIL;
                end
                M_TRAIL: begin
                    if (sentinel) begin
                        mode_next  = M_IDLE;
                        idx_next   = '0;
                        state_next = (kept_reg == '0) ? S_MARK : S_READ;
                    end else begin
                        rej_geo_next   = geo_reg;
                        rej_crate_next = crate_reg;
                        rej_drop_next  = drop_reg;
                        count_next     = low_reg[15:8];
                        geo_next       = s_word[15:11];
                        crate_next     = s_word[9:3];
                        pairs_next     = 9'd0;
                        kept_next      = '0;
                        drop_next      = 1'b0;
                        mode_next      = M_DATA;
                        state_next     = S_REJ;
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
        end

        unique case (state_reg)
            S_RUN: begin
            end
            S_READ: begin
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (res_ready) begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == kept_reg) ? S_MARK : S_READ;
                end
            end
            S_MARK, S_REJ: begin
                if (res_ready) begin
                    state_next = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb begin
        res_valid               = (state_reg == S_PUSH) || (state_reg == S_MARK)
                                  || (state_reg == S_REJ);
        res_beat.kind           = KIND_ENTRY;
        res_beat.channel_number = 5'd0;
        res_beat.sample_value   = 12'd0;
        res_beat.under_flag     = 1'b0;
        res_beat.over_flag      = 1'b0;
        res_beat.geo_address    = geo_reg;
        res_beat.crate_number   = crate_reg;
        res_beat.entry_total    = kept_reg[5:0];
        res_beat.truncated      = drop_reg;
        res_beat.is_last        = 1'b0;
        if (state_reg == S_PUSH) begin
            res_beat.channel_number = ram_rd_data[18:14];
            res_beat.under_flag     = ram_rd_data[13];
            res_beat.over_flag      = ram_rd_data[12];
            res_beat.sample_value   = ram_rd_data[11:0];
        end else if (state_reg == S_MARK) begin
            res_beat.kind    = KIND_ACCEPT;
            res_beat.is_last = 1'b1;
        end else if (state_reg == S_REJ) begin
            res_beat.kind         = KIND_REJECT;
            res_beat.geo_address  = rej_geo_reg;
            res_beat.crate_number = rej_crate_reg;
            res_beat.entry_total  = 6'd0;
            res_beat.truncated    = rej_drop_reg;
            res_beat.is_last      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
            mode_reg  <= M_IDLE;
            half_reg  <= 1'b0;
            low_reg   <= 16'd0;
            count_reg <= 8'd0;
            pairs_reg <= 9'd0;
            kept_reg  <= '0;
            idx_reg   <= '0;
            geo_reg   <= 5'd0;
            crate_reg <= 7'd0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            half_reg  <= half_next;
            low_reg   <= low_next;
            count_reg <= count_next;
            pairs_reg <= pairs_next;
            kept_reg  <= kept_next;
            idx_reg   <= idx_next;
            geo_reg   <= geo_next;
            crate_reg <= crate_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        rej_geo_reg   <= rej_geo_next;
        rej_crate_reg <= rej_crate_next;
        rej_drop_reg  <= rej_drop_next;
    end

endmodule

// ===== src/adc_event_stream_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_event_stream_unpacker
// Pairs 16-bit readout words into 32-bit words, parses header and data, and
// emits buffered channel entries with an accept or reject marker per event.
//
// The input channel (s_) takes one readout word per beat, low half first.
// The result channel (m_) delivers one entry or marker per beat through an
// output register, so the receiver can stall without losing anything.
// Words are taken at one per cycle while the event is being parsed; a word
// that causes no result never waits for the result channel.
// A closing sentinel pair starts the read-back of the entry buffer: each
// entry is read from the buffer (S_READ) and then handed to the output
// register (S_PUSH), and the accept marker follows (S_MARK); the input is
// held throughout the read-back. A reject marker (S_REJ) holds the input
// until it is taken. The buffer's single read port sets the read-then-push
// order per entry. Each result passes through the output register, and a
// buffered entry through the buffer's registered read data before that.
// Reset clears the parser, the counters and the output valid flag; the
// output beat and buffer contents stay undefined and are written before use.
// When the receiver stalls, the held beat stays on the ports and the
// read-back waits behind it.
// ----------------------------------------------------------------------------
module adc_event_stream_unpacker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [4:0]  m_channel_number,
    output logic [11:0] m_sample_value,
    output logic        m_under_flag,
    output logic        m_over_flag,
    output logic [4:0]  m_geo_address,
    output logic [6:0]  m_crate_number,
    output logic [5:0]  m_entry_total,
    output logic        m_truncated,
    output logic        m_is_last
);
    import aesu_pkg::*;

    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               res_valid;
    logic               res_ready;
    res_beat_t          res_beat;

    logic               out_valid_reg, out_valid_next;
    res_beat_t          out_beat_reg;

    aesu_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_beat    (res_beat)
    );

    aesu_entry_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_beat_reg <= res_beat;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_beat_reg.kind;
    assign m_channel_number = out_beat_reg.channel_number;
    assign m_sample_value   = out_beat_reg.sample_value;
    assign m_under_flag     = out_beat_reg.under_flag;
    assign m_over_flag      = out_beat_reg.over_flag;
    assign m_geo_address    = out_beat_reg.geo_address;
    assign m_crate_number   = out_beat_reg.crate_number;
    assign m_entry_total    = out_beat_reg.entry_total;
    assign m_truncated      = out_beat_reg.truncated;
    assign m_is_last        = out_beat_reg.is_last;

    a_no_input_during_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid
    ) else $error("input accepted while a result is pending");

    a_entry_not_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_ENTRY) |-> !m_is_last
    ) else $error("channel entry flagged as last");

    a_reject_total_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_REJECT) |-> (m_entry_total == 6'd0 && m_is_last)
    ) else $error("reject with nonzero total or not last");

    a_held_beat_blocks_readback: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (res_valid && out_valid_reg && !m_ready) |=> res_valid
    ) else $error("result dropped while output register was full");

endmodule
